@@ rtl/sffdo_pkg.sv @@
// Shared types and constants for the stereo frame FIFO that drops its oldest frame.
`timescale 1ns / 1ps

package sffdo_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int SAMPLE_W      = 16;
    localparam int FRAME_W       = 2 * SAMPLE_W;
    localparam int CAP_W         = 11;
    localparam int OVF_W         = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic                       clear_overflow;
        logic                       burst_last;
    } sffdo_in_t;

    typedef struct packed {
        logic                       read_valid;
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic [CAP_W-1:0]           fill_level;
        logic [OVF_W-1:0]           overflow_total;
        logic                       last;
    } sffdo_out_t;

endpackage

@@ rtl/stereo_frame_fifo_drop_oldest_core.sv @@
// Top level of the stereo frame FIFO that drops its oldest frame when full.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. busy is high only in a cycle in which cfg_we is high, so a
//   capacity write wins over a command in the same cycle.
//   Each command (write one frame or read one frame) gives one result on the
//   result port, marked by done, in the cycle right after it was taken.
//   Throughput is 1 transaction per cycle while busy is low; the frame memory
//   read port is registered.
//   A write into a full buffer drops the oldest frame and counts it in a
//   32-bit wrapping overflow counter. A read of an empty buffer returns
//   read_valid low and zero samples.
//   Configuration: cfg_we with cfg_data writes the capacity (0 acts as 1,
//   above DEPTH acts as DEPTH) and empties the buffer; the overflow counter
//   is kept.
//   Reset: indices, fill count and overflow counter go to zero, capacity to
//   1024; the frame memory is not cleared and needs no clearing pass.
//   The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module stereo_frame_fifo_drop_oldest_core
    import sffdo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sffdo_in_t        in_item,
    output logic             done,
    output sffdo_out_t       result,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = ((AW > CAP_W) ? AW : CAP_W) + 1;

    logic [CAP_W-1:0] capacity_reg;
    logic [AW-1:0]    wr_idx_reg, wr_idx_next;
    logic [AW-1:0]    rd_idx_reg, rd_idx_next;
    logic [CAP_W-1:0] count_reg, count_next;
    logic [OVF_W-1:0] ovf_reg, ovf_next, ovf_report;

    logic             done_reg;
    logic             valid_reg, valid_next;
    logic [CAP_W-1:0] fill_reg;
    logic [OVF_W-1:0] ovf_out_reg;
    logic             last_reg;

    logic             accept;
    logic [NW-1:0]    cap_ext, slots;
    logic [NW-1:0]    wr_inc, rd_inc;
    logic [AW-1:0]    wr_adv, rd_adv;
    logic             full, empty;
    logic             mem_wr_en, mem_rd_en;
    logic [FRAME_W-1:0] mem_rd_data;

    assign busy   = cfg_we;
    assign accept = start && !busy;

    always_comb
    begin
        cap_ext = NW'(capacity_reg);
        if (cap_ext == '0)
        begin
            slots = NW'(1);
        end
        else if (cap_ext > NW'(DEPTH))
        begin
            slots = NW'(DEPTH);
        end
        else
        begin
            slots = cap_ext;
        end
    end

    assign wr_inc = NW'(wr_idx_reg) + NW'(1);
    assign rd_inc = NW'(rd_idx_reg) + NW'(1);
    assign wr_adv = (wr_inc >= slots) ? '0 : wr_inc[AW-1:0];
    assign rd_adv = (rd_inc >= slots) ? '0 : rd_inc[AW-1:0];
    assign full   = NW'(count_reg) >= slots;
    assign empty  = count_reg == '0;

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        ovf_report  = ovf_reg;
        valid_next  = 1'b0;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        case (in_item.op)
            OP_WRITE:
            begin
                mem_wr_en   = 1'b1;
                wr_idx_next = wr_adv;
                if (full)
                begin
                    rd_idx_next = rd_adv;
                    ovf_report  = ovf_reg + OVF_W'(1);
                end
                else
                begin
                    count_next = count_reg + CAP_W'(1);
                end
            end
            OP_READ:
            begin
                if (!empty)
                begin
                    mem_rd_en   = 1'b1;
                    valid_next  = 1'b1;
                    rd_idx_next = rd_adv;
                    count_next  = count_reg - CAP_W'(1);
                end
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
        ovf_next = in_item.clear_overflow ? '0 : ovf_report;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            count_reg    <= '0;
            ovf_reg      <= '0;
            done_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_data;
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                wr_idx_reg <= wr_idx_next;
                rd_idx_reg <= rd_idx_next;
                count_reg  <= count_next;
                ovf_reg    <= ovf_next;
                valid_reg  <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fill_reg    <= count_next;
            ovf_out_reg <= ovf_report;
            last_reg    <= in_item.burst_last;
        end
    end

    sffdo_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_frame_mem (
        .clk     (clk),
        .wr_en   (accept && mem_wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data ({in_item.left_in, in_item.right_in}),
        .rd_en   (accept && mem_rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (mem_rd_data)
    );

    assign done                  = done_reg;
    assign result.read_valid     = valid_reg;
    assign result.left_out       = valid_reg ? mem_rd_data[FRAME_W-1:SAMPLE_W] : '0;
    assign result.right_out      = valid_reg ? mem_rd_data[SAMPLE_W-1:0] : '0;
    assign result.fill_level     = fill_reg;
    assign result.overflow_total = ovf_out_reg;
    assign result.last           = last_reg;

endmodule

@@ rtl/sffdo_frame_mem.sv @@
// Frame storage: one write port and one registered read port.
`timescale 1ns / 1ps

module sffdo_frame_mem
    import sffdo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [FRAME_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [FRAME_W-1:0] rd_data
);

    logic [FRAME_W-1:0] mem [DEPTH];
    logic [FRAME_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/sffdo_checker.sv @@
// Port-level assertion checker for the stereo frame FIFO, with its bind.
`timescale 1ns / 1ps

module sffdo_checker
    import sffdo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             done,
    input  sffdo_out_t       result
);

    logic accept;

    assign accept = start && !busy;

    a_done_follows_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> done
    ) else $error("transaction taken without a result in the next cycle");

    a_done_has_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(accept)
    ) else $error("result strobe without a transaction taken");

    a_empty_read_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && !result.read_valid) |-> (result.left_out == '0 && result.right_out == '0)
    ) else $error("samples not zero on a result without a frame");

    a_fill_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && $past(done)) |->
            ((CAP_W + 1)'(result.fill_level) == (CAP_W + 1)'($past(result.fill_level)) + 1'b1 ||
             result.fill_level == $past(result.fill_level) ||
             (CAP_W + 1)'(result.fill_level) + 1'b1 == (CAP_W + 1)'($past(result.fill_level)))
    ) else $error("fill level moved by more than one frame");

    a_valid_read_drains: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && $past(done) && result.read_valid) |->
            ((CAP_W + 1)'(result.fill_level) + 1'b1 == (CAP_W + 1)'($past(result.fill_level)))
    ) else $error("read returned a frame without lowering the fill level");

endmodule

bind stereo_frame_fifo_drop_oldest_core sffdo_checker u_sffdo_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .result   (result)
);
